>>> hdl/hmc_pkg.sv
// hmc_pkg: constants, types and table functions for the heat colormap pipeline
// knot positions in twentieths of full scale, knot colors, full-scale selection
// no dependencies
package hmc_pkg;

	localparam int KNOT_N = 7;
	localparam int CH_N   = 3;
	localparam int PIX_W  = 16;
	localparam int V20_W  = 21;   // 20 * 65535 fits
	localparam int DEN_W  = 18;   // widest span (4/20) times 65535
	localparam int NUM_W  = 18;   // offset into a segment never exceeds its span
	localparam int MAG_W  = 8;
	localparam int PROD_W = NUM_W + MAG_W;
	localparam int QUO_W  = 8;
	localparam int SEG_W  = 3;
	localparam int COL_W  = 8;

	typedef logic [1:0]       depth_t;
	typedef logic [SEG_W-1:0] seg_t;
	typedef logic [COL_W-1:0] col_t;

	localparam depth_t DEPTH_16 = 2'd0;
	localparam depth_t DEPTH_14 = 2'd1;
	localparam depth_t DEPTH_12 = 2'd2;
	localparam depth_t DEPTH_8  = 2'd3;

	localparam seg_t LAST_SEG = seg_t'(KNOT_N - 2);

	localparam logic [4:0] KNOT_POS [KNOT_N] = '{
		5'd0, 5'd4, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20
	};

	localparam col_t KNOT_RGB [KNOT_N][CH_N] = '{
		'{8'd0,   8'd8,   8'd60 },
		'{8'd0,   8'd50,  8'd180},
		'{8'd0,   8'd190, 8'd255},
		'{8'd0,   8'd230, 8'd120},
		'{8'd255, 8'd240, 8'd0  },
		'{8'd255, 8'd100, 8'd0  },
		'{8'd255, 8'd0,   8'd0  }
	};

	function automatic logic [PIX_W-1:0] full_scale(input depth_t d);
		logic [PIX_W-1:0] fs;
		unique case (d)
			DEPTH_16: fs = 16'd65535;
			DEPTH_14: fs = 16'd16383;
			DEPTH_12: fs = 16'd4095;
			DEPTH_8:  fs = 16'd255;
		endcase
		return fs;
	endfunction

	// knot k position scaled to 20 * pixel units
	function automatic logic [V20_W-1:0] knot_level(input depth_t d, input seg_t k);
		logic [V20_W-1:0] lvl;
		lvl = V20_W'(KNOT_POS[k]) * V20_W'(full_scale(d));
		return lvl;
	endfunction

	// segment width in 20 * pixel units
	function automatic logic [DEN_W-1:0] seg_span(input depth_t d, input seg_t s);
		logic [4:0]       span;
		logic [DEN_W-1:0] w;
		span = KNOT_POS[seg_t'(s + seg_t'(1))] - KNOT_POS[s];
		w    = DEN_W'(span) * DEN_W'(full_scale(d));
		return w;
	endfunction

endpackage

>>> hdl/heatmap_colormap_pixel.sv
// heatmap_colormap_pixel: 16-bit pixel to 8-bit rgb heat color, piecewise linear
// pipeline: done is the valid bit of the last of 12 registered stages behind start
// throughput: one pixel per clock; busy stays low, the receiver cannot stall
// stages: clamp and scale, segment search, color delta multiply, 8 restoring
// divide steps (one quotient bit each), add and clamp
// reset clears depth_q to 16-bit and all stage valid bits; uses hmc_pkg
module heatmap_colormap_pixel
	import hmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             start,
	output logic             busy,
	input  logic [PIX_W-1:0] pixel_value,
	input  logic             frame_end,
	output logic             done,
	output logic [COL_W-1:0] red,
	output logic [COL_W-1:0] green,
	output logic [COL_W-1:0] blue,
	output logic             frame_last
);

	depth_t depth_q;

	// stage 1: clamp and scale by 20
	logic             valid_s1, frame_s1;
	depth_t           mode_s1;
	logic [V20_W-1:0] v20_s1;

	// stage 2: segment and offset inside it
	logic             valid_s2, frame_s2;
	depth_t           mode_s2;
	seg_t             seg_s2;
	logic [NUM_W-1:0] num_s2;

	// divide pipeline, index 0 is stage 3, index i is stage 3 + i
	logic              div_valid_s [QUO_W+1];
	logic              div_frame_s [QUO_W+1];
	logic [DEN_W-1:0]  div_den_s   [QUO_W+1];
	logic              div_neg_s   [QUO_W+1][CH_N];
	col_t              div_c0_s    [QUO_W+1][CH_N];
	logic [PROD_W-1:0] div_rem_s   [QUO_W+1][CH_N];
	logic [QUO_W-1:0]  div_quo_s   [QUO_W+1][CH_N];

	// final stage
	logic valid_s12, frame_s12;
	col_t rgb_s12 [CH_N];

	logic [PIX_W-1:0] fs_in, v_clamp;
	logic [V20_W-1:0] v20_in;
	seg_t             seg_in;
	logic [V20_W-1:0] off_in;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_16;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	// stage 1 logic
	always_comb begin
		fs_in   = full_scale(depth_q);
		v_clamp = (pixel_value > fs_in) ? fs_in : pixel_value;
		v20_in  = (V20_W'(v_clamp) << 4) + (V20_W'(v_clamp) << 2);
	end

	// stage 2 logic: thresholds rise with k, so the last one passed wins
	always_comb begin
		seg_in = '0;
		for (int k = 1; k <= KNOT_N - 2; k++) begin
			if (v20_s1 > knot_level(mode_s1, seg_t'(k)))
				seg_in = seg_t'(k);
		end
		off_in = v20_s1 - knot_level(mode_s1, seg_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		frame_s1 <= frame_end;
		mode_s1  <= depth_q;
		v20_s1   <= v20_in;
		frame_s2 <= frame_s1;
		mode_s2  <= mode_s1;
		seg_s2   <= seg_in;
		num_s2   <= off_in[NUM_W-1:0];
	end

	// stage 3: per channel delta magnitude times offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_s[0] <= 1'b0;
		end else begin
			div_valid_s[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		div_frame_s[0] <= frame_s2;
		div_den_s[0]   <= seg_span(mode_s2, seg_s2);
		for (int ch = 0; ch < CH_N; ch++) begin
			col_t c0, c1;
			c0 = KNOT_RGB[seg_s2][ch];
			c1 = KNOT_RGB[seg_t'(seg_s2 + seg_t'(1))][ch];
			div_neg_s[0][ch] <= (c1 < c0);
			div_c0_s[0][ch]  <= c0;
			div_rem_s[0][ch] <= PROD_W'(num_s2) * PROD_W'((c1 < c0) ? (c0 - c1) : (c1 - c0));
			div_quo_s[0][ch] <= '0;
		end
	end

	// restoring divide, msb of the quotient first
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		localparam int SH = QUO_W - 1 - i;

		logic [PROD_W-1:0] trial;
		assign trial = PROD_W'(div_den_s[i]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[i+1] <= 1'b0;
			end else begin
				div_valid_s[i+1] <= div_valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			div_frame_s[i+1] <= div_frame_s[i];
			div_den_s[i+1]   <= div_den_s[i];
			for (int ch = 0; ch < CH_N; ch++) begin
				div_neg_s[i+1][ch] <= div_neg_s[i][ch];
				div_c0_s[i+1][ch]  <= div_c0_s[i][ch];
				if (div_rem_s[i][ch] >= trial) begin
					div_rem_s[i+1][ch] <= div_rem_s[i][ch] - trial;
					div_quo_s[i+1][ch] <= {div_quo_s[i][ch][QUO_W-2:0], 1'b1};
				end else begin
					div_rem_s[i+1][ch] <= div_rem_s[i][ch];
					div_quo_s[i+1][ch] <= {div_quo_s[i][ch][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	// final stage: floor toward minus infinity rounds a falling channel's step up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else begin
			valid_s12 <= div_valid_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		frame_s12 <= div_frame_s[QUO_W];
		for (int ch = 0; ch < CH_N; ch++) begin
			logic [QUO_W:0]   step;
			logic [COL_W+1:0] sum;
			step = {1'b0, div_quo_s[QUO_W][ch]}
				+ (QUO_W+1)'(div_neg_s[QUO_W][ch] && (div_rem_s[QUO_W][ch] != '0));
			if (div_neg_s[QUO_W][ch])
				sum = {2'b00, div_c0_s[QUO_W][ch]} - {1'b0, step};
			else
				sum = {2'b00, div_c0_s[QUO_W][ch]} + {1'b0, step};
			if (sum[COL_W+1])
				rgb_s12[ch] <= '0;
			else if (sum[COL_W])
				rgb_s12[ch] <= '1;
			else
				rgb_s12[ch] <= sum[COL_W-1:0];
		end
	end

	assign done       = valid_s12;
	assign frame_last = frame_s12;
	assign red        = rgb_s12[0];
	assign green      = rgb_s12[1];
	assign blue       = rgb_s12[2];

endmodule

>>> tb/tb.sv
// tb: self-checking bench for heatmap_colormap_pixel, pixel to rgb heat color mapper
// drives pixel transactions at the falling edge; compares every done strobe against a
// local integer model of the colormap; depends on hmc_pkg and the rtl only
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hmc_pkg::*;

	typedef enum logic [1:0] {STEP_PIXEL, STEP_DEPTH, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		logic [PIX_W-1:0] pix;
		logic             fe;
		depth_t           depth;
		int               idle_pct;
	} plan_step_t;

	typedef struct {
		col_t r;
		col_t g;
		col_t b;
		logic last;
	} heat_rgb_t;

	// knot positions in twentieths of full scale and the colors they carry
	localparam int KNOT_AT [7] = '{0, 4, 8, 11, 14, 17, 20};
	localparam int KNOT_COLOR [7][3] = '{
		'{  0,   8,  60},
		'{  0,  50, 180},
		'{  0, 190, 255},
		'{  0, 230, 120},
		'{255, 240,   0},
		'{255, 100,   0},
		'{255,   0,   0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_wdata = 2'd0;
	logic             start = 1'b0;
	logic             busy;
	logic [PIX_W-1:0] pixel_value = '0;
	logic             frame_end = 1'b0;
	logic             done;
	col_t             red;
	col_t             green;
	col_t             blue;
	logic             frame_last;

	plan_step_t pixel_plan [$];
	heat_rgb_t  colors_due [$];
	depth_t     depth_model = DEPTH_16;
	logic       took_q = 1'b0;
	int         mismatch_cnt = 0;

	heatmap_colormap_pixel dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.pixel_value (pixel_value),
		.frame_end   (frame_end),
		.done        (done),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_last  (frame_last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint scale_of(input depth_t mode);
		longint m;
		case (mode)
			DEPTH_16: m = 65535;
			DEPTH_14: m = 16383;
			DEPTH_12: m = 4095;
			default:  m = 255;
		endcase
		return m;
	endfunction

	function automatic heat_rgb_t heat_color(input logic [PIX_W-1:0] pix, input depth_t mode,
			input logic fe);
		longint    m, v, v20, num, den, dlt, prod, q, c;
		int        seg;
		longint    chan [3];
		heat_rgb_t res;
		m = scale_of(mode);
		v = pix;
		if (v > m)
			v = m;
		v20 = 20 * v;
		seg = 5;
		// scan downward so the lowest matching segment wins on a knot
		for (int i = 5; i >= 0; i--) begin
			if (v20 >= KNOT_AT[i] * m && v20 <= KNOT_AT[i+1] * m)
				seg = i;
		end
		num = v20 - KNOT_AT[seg] * m;
		den = (KNOT_AT[seg+1] - KNOT_AT[seg]) * m;
		for (int ch = 0; ch < 3; ch++) begin
			dlt  = KNOT_COLOR[seg+1][ch] - KNOT_COLOR[seg][ch];
			prod = num * dlt;
			// floor toward minus infinity for falling channels
			q = (prod >= 0) ? prod / den : -((-prod + den - 1) / den);
			c = KNOT_COLOR[seg][ch] + q;
			if (c < 0)
				c = 0;
			if (c > 255)
				c = 255;
			chan[ch] = c;
		end
		res.r    = col_t'(chan[0]);
		res.g    = col_t'(chan[1]);
		res.b    = col_t'(chan[2]);
		res.last = fe;
		return res;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(input depth_t mode);
		longint m, p;
		int     roll, k;
		m    = scale_of(mode);
		roll = $urandom_range(99);
		if (roll < 15) begin
			p = $urandom_range(65535);
		end else if (roll < 40) begin
			// close to a knot, where segment choice and rounding matter
			k = $urandom_range(6);
			p = (KNOT_AT[k] * m) / 20 + $urandom_range(4) - 2;
			if (p < 0)
				p = 0;
			if (p > 65535)
				p = 65535;
		end else if (roll < 50 && m < 65535) begin
			p = $urandom_range(65535, m);
		end else begin
			p = $urandom_range(m);
		end
		return PIX_W'(p);
	endfunction

	task automatic add_pixel(input logic [PIX_W-1:0] pix, input logic fe, input int pct);
		plan_step_t s;
		s.kind     = STEP_PIXEL;
		s.pix      = pix;
		s.fe       = fe;
		s.depth    = DEPTH_16;
		s.idle_pct = pct;
		pixel_plan.push_back(s);
	endtask

	task automatic add_ctrl(input step_kind_t kind, input depth_t mode);
		plan_step_t s;
		s.kind     = kind;
		s.pix      = '0;
		s.fe       = 1'b0;
		s.depth    = mode;
		s.idle_pct = 0;
		pixel_plan.push_back(s);
	endtask

	// driver: one nonblocking update per input per falling edge
	always @(negedge clk) begin
		plan_step_t       nxt;
		logic             nx_start, nx_we, nx_fe;
		logic [1:0]       nx_wd;
		logic [PIX_W-1:0] nx_pix;
		nx_start = start;
		nx_we    = 1'b0;
		nx_wd    = cfg_wdata;
		nx_pix   = pixel_value;
		nx_fe    = frame_end;
		if (arst_n && (!start || took_q)) begin
			nx_start = 1'b0;
			if (pixel_plan.size() != 0) begin
				nxt = pixel_plan[0];
				case (nxt.kind)
					STEP_PIXEL: begin
						if ($urandom_range(99) >= nxt.idle_pct) begin
							void'(pixel_plan.pop_front());
							nx_start = 1'b1;
							nx_pix   = nxt.pix;
							nx_fe    = nxt.fe;
						end
					end
					STEP_DRAIN: begin
						if (colors_due.size() == 0)
							void'(pixel_plan.pop_front());
					end
					STEP_DEPTH: begin
						// register writes only with the pipeline empty
						if (colors_due.size() == 0) begin
							void'(pixel_plan.pop_front());
							nx_we = 1'b1;
							nx_wd = nxt.depth;
						end
					end
					default: void'(pixel_plan.pop_front());
				endcase
			end
		end
		start       <= nx_start;
		cfg_we      <= nx_we;
		cfg_wdata   <= nx_wd;
		pixel_value <= nx_pix;
		frame_end   <= nx_fe;
	end

	// monitor: predict on accepted transactions, check every done strobe
	always @(posedge clk) begin
		heat_rgb_t want;
		took_q <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (colors_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: result with no pending transaction: rgb %0d %0d %0d last %b",
							$realtime, red, green, blue, frame_last);
				end else begin
					want = colors_due.pop_front();
					if (red !== want.r || green !== want.g || blue !== want.b
							|| frame_last !== want.last) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("%0t: mismatch: rgb %0d %0d %0d last %b, expected %0d %0d %0d last %b",
								$realtime, red, green, blue, frame_last,
								want.r, want.g, want.b, want.last);
					end
				end
			end
			if (start && !busy)
				colors_due.push_back(heat_color(pixel_value, depth_model, frame_end));
			if (cfg_we)
				depth_model <= depth_t'(cfg_wdata);
		end
	end

	initial begin
		depth_t phase_depth [4];
		int     phase_idle [4];
		int     wait_cnt;

		phase_depth = '{DEPTH_12, DEPTH_8, DEPTH_16, DEPTH_14};
		phase_idle  = '{0, 85, 0, 32};

		// directed: reset depth first, then 8-bit and 14-bit extremes
		add_pixel(16'd0, 1'b0, 0);
		add_pixel(16'd65535, 1'b1, 0);
		add_pixel(16'd13107, 1'b0, 0);
		add_pixel(16'd26214, 1'b1, 0);
		add_pixel(16'd36044, 1'b0, 0);
		add_pixel(16'd36045, 1'b0, 0);
		add_pixel(16'd45874, 1'b0, 0);
		add_pixel(16'd45875, 1'b0, 0);
		add_pixel(16'd55705, 1'b0, 0);
		add_pixel(16'h5555, 1'b1, 0);
		add_pixel(16'hAAAA, 1'b0, 0);
		add_ctrl(STEP_DEPTH, DEPTH_8);
		add_pixel(16'd0, 1'b0, 0);
		add_pixel(16'd51, 1'b0, 0);
		add_pixel(16'd102, 1'b1, 0);
		add_pixel(16'd140, 1'b0, 0);
		add_pixel(16'd141, 1'b0, 0);
		add_pixel(16'd255, 1'b0, 0);
		add_pixel(16'd256, 1'b0, 0);
		add_pixel(16'hFFFF, 1'b1, 0);
		add_ctrl(STEP_DEPTH, DEPTH_14);
		add_pixel(16'd16383, 1'b0, 0);
		add_pixel(16'd16384, 1'b1, 0);
		add_pixel(16'd3276, 1'b0, 0);

		for (int p = 0; p < 16; p++) begin
			add_ctrl(STEP_DEPTH, phase_depth[p % 4]);
			for (int n = 0; n < 108; n++) begin
				if (n == 54)
					add_ctrl(STEP_DRAIN, DEPTH_16);
				add_pixel(pick_pixel(phase_depth[p % 4]), ($urandom_range(7) == 0),
					phase_idle[p / 4]);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pixel_plan.size() != 0 || start)
			@(posedge clk);
		wait_cnt = 0;
		while (colors_due.size() != 0 && wait_cnt < 200) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (16) @(posedge clk);
		mismatch_cnt += colors_due.size();

		if (mismatch_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
